@@ rtl/core/kpcalc_pkg.sv @@
// Shared types and codes for the keypad four-function calculator.
// No dependencies.
package kpcalc_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned StepW  = $clog2(DataW);
  localparam int unsigned DigitW = 4;

  typedef enum logic [1:0] {
    KEY_DIGIT    = 2'd0,
    KEY_OPERATOR = 2'd1,
    KEY_EQUALS   = 2'd2,
    KEY_CLEAR    = 2'd3
  } key_t;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_MUL,
    ST_DIV,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/core/keypad_four_function_calculator_top.sv @@
// Keypad four-function calculator: key transactions in, results out.
// One shared 33-bit add/subtract unit under a small sequencer.
// Depends on kpcalc_pkg.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_stall  | in_opcode, in_digit_value, in_operator_kind
//  out     | out_valid/out_stall| out_result_bits, out_divide_error
//
// Operator, clear and idle equals keys finish in ST_IDLE; digit keys do x10 there,
// then +digit in ST_DIGIT. Equals: add/subtract and divide by zero go on to ST_EMIT;
// multiply and divide first run 32 shift-add or restoring steps on the shared adder.
// ST_EMIT waits on a stalled output register. in_stall is high while a key is being
// worked on; a result waits in the output register while the next key is taken.
// Synchronous active-low reset clears state, pending op, entry, first and out_valid.
module keypad_four_function_calculator_top
  import kpcalc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic [DigitW-1:0] in_digit_value,
  input  logic [1:0]        in_operator_kind,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DataW-1:0]  out_result_bits,
  output logic              out_divide_error
);

  state_t state_r, state_nxt;
  op_t    pend_r, pend_nxt;
  logic [DataW-1:0]  entry_r, entry_nxt;
  logic [DataW-1:0]  first_r, first_nxt;
  logic [DataW-1:0]  acc_r, acc_nxt;
  logic [DataW-1:0]  wa_r, wa_nxt;
  logic [DataW-1:0]  wb_r, wb_nxt;
  logic [StepW-1:0]  cnt_r, cnt_nxt;
  logic [DigitW-1:0] digit_r, digit_nxt;
  logic              err_r, err_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DataW-1:0]  out_res_r, out_res_nxt;
  logic              out_err_r, out_err_nxt;

  logic [DataW:0]    add_a, add_b;
  logic              add_sub;
  logic [DataW+1:0]  sum;
  logic              in_acc;
  key_t              key;

  assign key     = key_t'(in_opcode);
  assign in_acc  = in_valid && !in_stall;
  assign sum     = {1'b0, add_a} + {1'b0, add_b ^ {(DataW+1){add_sub}}}
                 + {{(DataW+1){1'b0}}, add_sub};

  // shared adder operand select
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (key == KEY_DIGIT) begin
          add_a = {1'b0, entry_r[DataW-4:0], 3'b000};
          add_b = {1'b0, entry_r[DataW-2:0], 1'b0};
        end else begin
          add_a   = {1'b0, first_r};
          add_b   = {1'b0, entry_r};
          add_sub = (pend_r == OP_SUB);
        end
      end
      ST_DIGIT: begin
        add_a = {1'b0, acc_r};
        add_b = {{(DataW+1-DigitW){1'b0}}, digit_r};
      end
      ST_MUL: begin
        add_a = {1'b0, acc_r};
        add_b = {1'b0, wa_r};
      end
      ST_DIV: begin
        add_a   = {acc_r, wa_r[DataW-1]};
        add_b   = {1'b0, wb_r};
        add_sub = 1'b1;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    entry_nxt     = entry_r;
    first_nxt     = first_r;
    acc_nxt       = acc_r;
    wa_nxt        = wa_r;
    wb_nxt        = wb_r;
    cnt_nxt       = cnt_r;
    digit_nxt     = digit_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    out_err_nxt   = out_err_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (key)
            KEY_DIGIT: begin
              acc_nxt   = sum[DataW-1:0];
              digit_nxt = in_digit_value;
              state_nxt = ST_DIGIT;
            end
            KEY_OPERATOR: begin
              first_nxt = entry_r;
              entry_nxt = '0;
              pend_nxt  = op_t'(3'({1'b0, in_operator_kind}) + 3'd1);
            end
            KEY_CLEAR: begin
              entry_nxt = '0;
              first_nxt = '0;
              pend_nxt  = OP_NONE;
            end
            KEY_EQUALS: begin
              if (pend_r != OP_NONE) begin
                entry_nxt = '0;
                first_nxt = '0;
                pend_nxt  = OP_NONE;
                err_nxt   = 1'b0;
                cnt_nxt   = '0;
                wa_nxt    = first_r;
                wb_nxt    = entry_r;
                case (pend_r)
                  OP_ADD, OP_SUB: begin
                    acc_nxt   = sum[DataW-1:0];
                    state_nxt = ST_EMIT;
                  end
                  OP_MUL: begin
                    acc_nxt   = '0;
                    state_nxt = ST_MUL;
                  end
                  default: begin
                    acc_nxt = '0;
                    if (entry_r == '0) begin
                      err_nxt   = 1'b1;
                      state_nxt = ST_EMIT;
                    end else begin
                      state_nxt = ST_DIV;
                    end
                  end
                endcase
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_DIGIT: begin
        entry_nxt = sum[DataW-1:0];
        state_nxt = ST_IDLE;
      end
      ST_MUL: begin
        if (wb_r[0]) begin
          acc_nxt = sum[DataW-1:0];
        end
        wa_nxt  = {wa_r[DataW-2:0], 1'b0};
        wb_nxt  = {1'b0, wb_r[DataW-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DIV: begin
        // restoring step: carry out of the subtract means no borrow
        acc_nxt = sum[DataW+1] ? sum[DataW-1:0] : add_a[DataW-1:0];
        wa_nxt  = {wa_r[DataW-2:0], sum[DataW+1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          acc_nxt   = {wa_r[DataW-2:0], sum[DataW+1]};
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = acc_r;
          out_err_nxt   = err_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= OP_NONE;
      entry_r     <= '0;
      first_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      entry_r     <= entry_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    wa_r      <= wa_nxt;
    wb_r      <= wb_nxt;
    cnt_r     <= cnt_nxt;
    digit_r   <= digit_nxt;
    err_r     <= err_nxt;
    out_res_r <= out_res_nxt;
    out_err_r <= out_err_nxt;
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_bits  = out_res_r;
  assign out_divide_error = out_err_r;

  a_clear_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && key == KEY_CLEAR) |=> (!in_stall && pend_r == OP_NONE && entry_r == '0))
    else $error("clear key did not finish in one cycle");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_error) |-> (out_result_bits == '0))
    else $error("divide error with nonzero result");

  a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_MUL || state_r == ST_DIV) && cnt_r != '1)
      |=> (state_r == $past(state_r) && cnt_r == $past(cnt_r) + 1'b1))
    else $error("iterative step sequence broken");

  a_no_pending_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && key == KEY_EQUALS && pend_r == OP_NONE) |=> (state_r == ST_IDLE))
    else $error("equals with nothing pending started work");

endmodule
